// File: design/xor_key_base64_codec_defines.svh
// Assertion macros shared by the codec RTL.
// Used by files that carry concurrent checks; no other dependencies.
`ifndef XOR_KEY_BASE64_CODEC_DEFINES_SVH
`define XOR_KEY_BASE64_CODEC_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define XKB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define XKB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/xkb_pkg.sv
// Shared types, constants and base64 mapping functions for the codec.
// No dependencies; imported by every codec module.
package xkb_pkg;

  localparam int MAX_KEY_BYTES = 24;
  localparam int KEY_IDX_W = $clog2(MAX_KEY_BYTES);
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef enum logic [2:0] {
    CFG_MODE      = 3'd0,
    CFG_KEY_LEN   = 3'd1,
    CFG_KEY_LOW   = 3'd2,
    CFG_KEY_MID   = 3'd3,
    CFG_KEY_HIGH  = 3'd4
  } cfg_reg_t;

  // One queued job: up to three data results followed by pad characters.
  typedef struct packed {
    logic [2:0][7:0] chars;
    logic [1:0]      nchars;
    logic [1:0]      npad;
    logic            dvalid;
    logic            last;
  } entry_t;

  function automatic logic [7:0] b64_enc(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'd71 + {2'b00, v};
    end else if (v < 6'd62) begin
      c = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      c = 8'd43;
    end else begin
      c = 8'd47;
    end
    return c;
  endfunction

  // Returns {hit, value}; hit is low for characters outside the alphabet.
  function automatic logic [6:0] b64_dec(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'd65 && c <= 8'd90) begin
      r = {1'b1, 6'(c - 8'd65)};
    end else if (c >= 8'd97 && c <= 8'd122) begin
      r = {1'b1, 6'(c - 8'd71)};
    end else if (c >= 8'd48 && c <= 8'd57) begin
      r = {1'b1, 6'(c + 8'd4)};
    end else if (c == 8'd43) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'd47) begin
      r = {1'b1, 6'd63};
    end else begin
      r = 7'd0;
    end
    return r;
  endfunction

endpackage

// File: design/xkb_front.sv
// Front end: configuration registers, key stream, bit packing and job building.
// Depends on xkb_pkg; feeds jobs to xkb_fifo.
module xkb_front import xkb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_in,
  input  logic        end_of_message,
  input  logic        q_full,
  output logic        q_push,
  output entry_t      q_entry
);

  logic                 mode;
  logic [4:0]           key_length;
  logic [63:0]          key_low;
  logic [63:0]          key_mid;
  logic [63:0]          key_high;
  logic [11:0]          bit_buffer;
  logic [3:0]           pending_bits;
  logic [KEY_IDX_W-1:0] key_index;
  logic [1:0]           chars_mod_four;
  logic                 padding_seen;

  logic                 accept;
  logic [4:0]           len;
  logic [KEY_IDX_W-1:0] idx;
  logic [KEY_IDX_W-1:0] key_index_next;
  logic [191:0]         key_all;
  logic [7:0]           kb;

  logic [11:0]          buf_e;
  logic [3:0]           pend_e, p1, p2, rem_e;
  logic                 two;
  logic                 flush;
  logic [5:0]           flush_bits;
  logic [7:0]           c1, c2, cf;
  logic [1:0]           nchars_e;
  logic [1:0]           cm_after;

  logic [6:0]           dec;
  logic                 is_pad;
  logic [11:0]          buf_d;
  logic [3:0]           pend_d, pd2;
  logic                 got;
  logic [7:0]           byte_d;

  assign accept   = in_valid && in_ready;
  assign in_ready = !q_full;
  assign key_all  = {key_high, key_mid, key_low};

  always_comb begin
    if (key_length == 5'd0) begin
      len = 5'd1;
    end else if (key_length > 5'(MAX_KEY_BYTES)) begin
      len = 5'(MAX_KEY_BYTES);
    end else begin
      len = key_length;
    end
    idx = (5'(key_index) < len) ? key_index : '0;
    key_index_next = (5'(idx) + 5'd1 >= len) ? '0 : KEY_IDX_W'(5'(idx) + 5'd1);
    kb = key_all[{idx, 3'b000} +: 8];
  end

  always_comb begin
    buf_e      = {bit_buffer[3:0], data_in ^ kb};
    pend_e     = pending_bits + 4'd8;
    p1         = pend_e - 4'd6;
    two        = p1 >= 4'd6;
    p2         = p1 - 4'd6;
    rem_e      = two ? p2 : p1;
    flush      = end_of_message && (rem_e != 4'd0);
    flush_bits = buf_e[5:0] << 3'(4'd6 - rem_e);
    c1         = b64_enc(6'(buf_e >> p1));
    c2         = b64_enc(6'(buf_e >> p2));
    cf         = b64_enc(flush_bits);
    nchars_e   = 2'd1 + {1'b0, two} + {1'b0, flush};
    cm_after   = chars_mod_four + nchars_e;
  end

  always_comb begin
    dec    = b64_dec(data_in);
    is_pad = data_in == PAD_CHAR;
    buf_d  = {bit_buffer[5:0], dec[5:0]};
    pend_d = pending_bits + 4'd6;
    pd2    = pend_d - 4'd8;
    got    = !padding_seen && !is_pad && dec[6] && (pend_d >= 4'd8);
    byte_d = 8'(buf_d >> pd2) ^ kb;
  end

  always_comb begin
    q_entry = '0;
    if (mode == 1'b0) begin
      q_entry.chars[0] = c1;
      q_entry.chars[1] = two ? c2 : cf;
      q_entry.chars[2] = cf;
      q_entry.nchars   = nchars_e;
      q_entry.npad     = end_of_message ? 2'(3'd4 - {1'b0, cm_after}) : 2'd0;
      q_entry.dvalid   = 1'b1;
      q_entry.last     = end_of_message;
    end else begin
      q_entry.chars[0] = got ? byte_d : 8'd0;
      q_entry.nchars   = 2'd1;
      q_entry.npad     = 2'd0;
      q_entry.dvalid   = got;
      q_entry.last     = end_of_message;
    end
    q_push = accept && ((mode == 1'b0) || got || end_of_message);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b0;
      key_length <= 5'd20;
      key_low    <= '0;
      key_mid    <= '0;
      key_high   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:     mode       <= cfg_data[0];
        CFG_KEY_LEN:  key_length <= cfg_data[4:0];
        CFG_KEY_LOW:  key_low    <= cfg_data;
        CFG_KEY_MID:  key_mid    <= cfg_data;
        CFG_KEY_HIGH: key_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cfg_we && cfg_index == CFG_MODE) || (accept && end_of_message)) begin
      bit_buffer     <= '0;
      pending_bits   <= '0;
      key_index      <= '0;
      chars_mod_four <= '0;
      padding_seen   <= 1'b0;
    end else if (accept) begin
      if (mode == 1'b0) begin
        bit_buffer     <= buf_e;
        pending_bits   <= rem_e;
        key_index      <= key_index_next;
        chars_mod_four <= cm_after;
      end else if (!padding_seen) begin
        if (is_pad) begin
          padding_seen <= 1'b1;
        end else if (dec[6]) begin
          bit_buffer   <= buf_d;
          pending_bits <= got ? pd2 : pend_d;
          if (got) begin
            key_index <= key_index_next;
          end
        end
      end
    end
  end

endmodule

// File: design/xkb_fifo.sv
// Two-entry job queue between the front end and the result serializer.
// Depends on xkb_pkg for the job type.
module xkb_fifo import xkb_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  entry_t     slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head       = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: design/xkb_back.sv
// Back end: walks each queued job and drives one result per transfer.
// Depends on xkb_pkg and the assertion macros header.
`include "xor_key_base64_codec_defines.svh"
module xkb_back import xkb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  entry_t     head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_out,
  output logic       data_valid,
  output logic       last_out
);

  logic [2:0] pos;
  logic [2:0] total;
  logic       load;
  logic       at_end;

  assign total  = 3'(head.nchars) + 3'(head.npad);
  assign at_end = pos == total - 3'd1;
  assign load   = head_valid && (!out_valid || out_ready);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (load) begin
      data_out   <= (pos < 3'(head.nchars)) ? head.chars[pos[1:0]] : PAD_CHAR;
      data_valid <= (pos < 3'(head.nchars)) ? head.dvalid : 1'b1;
      last_out   <= head.last && at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= 3'd0;
    end else begin
      out_valid <= load || (out_valid && !out_ready);
      if (load) begin
        pos <= at_end ? 3'd0 : pos + 3'd1;
      end
    end
  end

  `XKB_ASSERT_NOW(a_pos_in_job, head_valid, pos < total, "result index beyond job")
  `XKB_ASSERT_NEXT(a_job_held, load && !pop, head_valid, "job lost before its last result")
  `XKB_ASSERT_NOW(a_marker_last, out_valid && !data_valid, last_out, "bare marker not last")

endmodule

// File: design/xor_key_base64_codec.sv
// Top level of the repeating-key XOR codec with base64 framing.
// Depends on xkb_pkg, xkb_front, xkb_fifo and xkb_back.
//
// Channel  | Handshake            | Payload
// input    | in_valid / in_ready  | data_in, end_of_message
// output   | out_valid / out_ready| data_out, data_valid, last_out
// config   | cfg_we               | cfg_index, cfg_data
//
// An input transfer is taken by the front end; each result then passes the output
// register, one result per output transfer.
// Encoding throughput is set by the single result port.
// An input reaches the output through a job queue slot and then the output register.
// Reset is synchronous and clears control state; a stalled output holds and
// the two-entry queue lets the front end keep accepting until it fills.
module xor_key_base64_codec import xkb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_in,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_out,
  output logic        data_valid,
  output logic        last_out
);

  logic   q_full;
  logic   q_push;
  entry_t q_entry;
  logic   q_pop;
  logic   q_head_valid;
  entry_t q_head;

  xkb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_in        (data_in),
    .end_of_message (end_of_message),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (q_entry)
  );

  xkb_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  xkb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_out   (data_out),
    .data_valid (data_valid),
    .last_out   (last_out)
  );

endmodule
